// ----- src/hsl_pkg.sv -----
// hsl_pkg: widths, constants, types and helper functions shared by the
// hsl to rgb pipeline; no dependencies
package hsl_pkg;

    localparam int FRAC_BITS = 8;
    localparam int LVL_W     = FRAC_BITS + 1;
    localparam int HUE_W     = 9;
    localparam int SEG       = 60;
    localparam int K_W       = 6;
    localparam int P_W       = LVL_W + K_W;
    // reciprocal of the segment width, exact for every product below 2**P_W
    localparam int SH        = P_W + 6;
    localparam int RC_W      = P_W + 1;
    localparam int M_W       = P_W + RC_W;
    localparam longint RECIP_L = ((longint'(1) << SH) + longint'(SEG - 1)) / longint'(SEG);
    localparam logic [RC_W-1:0] RECIP = RC_W'(RECIP_L);

    localparam logic [LVL_W-1:0] ONE  = LVL_W'(1) << FRAC_BITS;
    localparam logic [LVL_W-1:0] HALF = LVL_W'(1) << (FRAC_BITS - 1);

    localparam logic [HUE_W-1:0] DEG_60  = HUE_W'(SEG);
    localparam logic [HUE_W-1:0] DEG_120 = HUE_W'(2 * SEG);
    localparam logic [HUE_W-1:0] DEG_180 = HUE_W'(3 * SEG);
    localparam logic [HUE_W-1:0] DEG_240 = HUE_W'(4 * SEG);
    localparam logic [HUE_W-1:0] DEG_360 = HUE_W'(6 * SEG);

    typedef enum logic [1:0] {
        RG_UP = 2'b00,
        RG_HI = 2'b01,
        RG_DN = 2'b10,
        RG_LO = 2'b11
    } t_region;

    typedef struct packed {
        t_region          region;
        logic [K_W-1:0]   k;
    } t_chan;

    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } t_prep_ctl;

    typedef struct packed {
        logic en4;
        logic en5;
    } t_ramp_ctl;

    function automatic logic [LVL_W-1:0] sat_one(logic [LVL_W-1:0] x);
        return (x > ONE) ? ONE : x;
    endfunction

    // picks the ramp segment for one channel angle and the step into it
    function automatic t_chan ramp_sel(logic [HUE_W-1:0] d);
        t_chan c;
        c.k = '0;
        if (d < DEG_60) begin
            c.region = RG_UP;
            c.k      = K_W'(d);
        end else if (d < DEG_180) begin
            c.region = RG_HI;
        end else if (d < DEG_240) begin
            c.region = RG_DN;
            c.k      = K_W'(DEG_240 - d);
        end else begin
            c.region = RG_LO;
        end
        return c;
    endfunction

endpackage

// ----- src/hsl_in_if.sv -----
// hsl_in_if: valid/ready channel carrying one hsl word
// depends on hsl_pkg for field widths
interface hsl_in_if;
    logic                        valid;
    logic                        ready;
    logic [hsl_pkg::HUE_W-1:0]   hue_deg;
    logic [hsl_pkg::LVL_W-1:0]   saturation;
    logic [hsl_pkg::LVL_W-1:0]   lightness;

    modport source (output valid, hue_deg, saturation, lightness, input ready);
    modport sink   (input valid, hue_deg, saturation, lightness, output ready);
endinterface

// ----- src/hsl_out_if.sv -----
// hsl_out_if: valid/ready channel carrying one rgb word
// depends on hsl_pkg for field widths
interface hsl_out_if;
    logic                        valid;
    logic                        ready;
    logic [hsl_pkg::LVL_W-1:0]   red;
    logic [hsl_pkg::LVL_W-1:0]   green;
    logic [hsl_pkg::LVL_W-1:0]   blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

// ----- src/hsl_prep.sv -----
// hsl_prep: pipeline stages one to three, input clamp, l*s product,
// upper/lower levels and per-channel ramp segment; uses hsl_pkg
module hsl_prep (
    input  logic                        i_clk,
    input  hsl_pkg::t_prep_ctl          i_ctl,
    input  logic [hsl_pkg::HUE_W-1:0]   i_hue,
    input  logic [hsl_pkg::LVL_W-1:0]   i_sat,
    input  logic [hsl_pkg::LVL_W-1:0]   i_light,
    output logic [hsl_pkg::LVL_W-1:0]   o_lo,
    output logic [hsl_pkg::LVL_W-1:0]   o_hi,
    output logic [hsl_pkg::LVL_W-1:0]   o_span,
    output hsl_pkg::t_chan [2:0]        o_chan
);
    import hsl_pkg::*;

    logic [HUE_W-1:0]     r_h1, r_h2, n_h1;
    logic [LVL_W-1:0]     r_s1, r_l1, r_s2, r_l2, r_ls2;
    logic [2*LVL_W-1:0]   n_prod;
    logic [LVL_W:0]       n_up, n_dn, n_sum;
    logic [LVL_W-1:0]     n_v2, n_v2c, n_v1;
    logic [LVL_W:0]       n_twol;
    logic [HUE_W-1:0]     n_dr, n_db;
    logic [LVL_W-1:0]     r_lo3, r_hi3, r_span3;
    t_chan [2:0]          r_chan3, n_chan;

    // stage one: wrap hue once, clamp levels to one
    always_comb begin
        n_h1 = (i_hue >= DEG_360) ? (i_hue - DEG_360) : i_hue;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en1) begin
            r_h1 <= n_h1;
            r_s1 <= sat_one(i_sat);
            r_l1 <= sat_one(i_light);
        end
    end

    // stage two: truncated l*s
    always_comb begin
        n_prod = (2*LVL_W)'(r_l1) * (2*LVL_W)'(r_s1);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en2) begin
            r_h2  <= r_h1;
            r_s2  <= r_s1;
            r_l2  <= r_l1;
            r_ls2 <= n_prod[FRAC_BITS +: LVL_W];
        end
    end

    // stage three: levels and channel angles
    always_comb begin
        n_up   = {1'b0, r_l2} + {1'b0, r_ls2};
        n_dn   = {1'b0, r_l2} + {1'b0, r_s2} - {1'b0, r_ls2};
        n_sum  = (r_l2 < HALF) ? n_up : n_dn;
        n_v2   = (n_sum > {1'b0, ONE}) ? ONE : n_sum[LVL_W-1:0];
        n_v2c  = (n_v2 < r_l2) ? r_l2 : n_v2;
        n_twol = {r_l2, 1'b0};
        n_v1   = ({1'b0, n_v2c} > n_twol) ? n_v2c : LVL_W'(n_twol - {1'b0, n_v2c});

        n_dr = (r_h2 >= DEG_240) ? (r_h2 - DEG_240) : (r_h2 + DEG_120);
        n_db = (r_h2 >= DEG_120) ? (r_h2 - DEG_120) : (r_h2 + DEG_240);
        n_chan[0] = ramp_sel(n_dr);
        n_chan[1] = ramp_sel(r_h2);
        n_chan[2] = ramp_sel(n_db);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en3) begin
            r_lo3   <= n_v1;
            r_hi3   <= n_v2c;
            r_span3 <= n_v2c - n_v1;
            r_chan3 <= n_chan;
        end
    end

    assign o_lo   = r_lo3;
    assign o_hi   = r_hi3;
    assign o_span = r_span3;
    assign o_chan = r_chan3;

endmodule

// ----- src/hsl_ramp.sv -----
// hsl_ramp: pipeline stages four and five for one channel, span*step,
// divide by the segment width through a reciprocal, pick the level; uses hsl_pkg
module hsl_ramp (
    input  logic                        i_clk,
    input  hsl_pkg::t_ramp_ctl          i_ctl,
    input  hsl_pkg::t_chan              i_chan,
    input  logic [hsl_pkg::LVL_W-1:0]   i_lo,
    input  logic [hsl_pkg::LVL_W-1:0]   i_hi,
    input  logic [hsl_pkg::LVL_W-1:0]   i_span,
    output logic [hsl_pkg::LVL_W-1:0]   o_level
);
    import hsl_pkg::*;

    logic [P_W-1:0]     r_p4, n_p;
    t_region            r_region4;
    logic [LVL_W-1:0]   r_lo4, r_hi4;
    logic [M_W-1:0]     n_m;
    logic [LVL_W-1:0]   n_q, n_level, r_level5;

    always_comb begin
        n_p = P_W'(i_span) * P_W'(i_chan.k);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en4) begin
            r_p4      <= n_p;
            r_region4 <= i_chan.region;
            r_lo4     <= i_lo;
            r_hi4     <= i_hi;
        end
    end

    always_comb begin
        n_m = M_W'(r_p4) * M_W'(RECIP);
        n_q = n_m[SH +: LVL_W];
        case (r_region4)
            RG_UP:   n_level = r_lo4 + n_q;
            RG_DN:   n_level = r_lo4 + n_q;
            RG_HI:   n_level = r_hi4;
            RG_LO:   n_level = r_lo4;
            default: n_level = r_lo4;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en5) begin
            r_level5 <= n_level;
        end
    end

    assign o_level = r_level5;

endmodule

// ----- src/hsl_to_rgb_core.sv -----
// hsl_to_rgb_core: top level, five-stage hsl to rgb pipeline with valid bits
// depends on hsl_pkg, hsl_in_if, hsl_out_if, hsl_prep, hsl_ramp
//
//  channel  dir  fields                              handshake
//  i_pix    in   hue_deg, saturation, lightness      valid/ready
//  o_rgb    out  red, green, blue                    valid/ready
//
// one word per cycle while o_rgb is not stalled; o_rgb.valid is the valid bit
// of stage five, so a word passes stages one to five before its output handshake
// the depth is set by the multipliers: l*s, span*step and the
// reciprocal multiply of the divide by sixty each sit in a stage of their own
// reset clears the stage valid bits only
// a stage moves when it is empty or the one after it moves, so bubbles close up
// and input is still taken during an output stall until all five stages hold a word
module hsl_to_rgb_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hsl_in_if.sink      i_pix,
    hsl_out_if.source   o_rgb
);
    import hsl_pkg::*;

    logic [5:1]           r_vld;
    logic [5:1]           n_adv;
    t_prep_ctl            n_prep_ctl;
    t_ramp_ctl            n_ramp_ctl;
    logic [LVL_W-1:0]     n_lo, n_hi, n_span;
    t_chan [2:0]          n_chan;
    logic [LVL_W-1:0]     n_level [3];

    always_comb begin
        n_adv[5] = !r_vld[5] || o_rgb.ready;
        n_adv[4] = !r_vld[4] || n_adv[5];
        n_adv[3] = !r_vld[3] || n_adv[4];
        n_adv[2] = !r_vld[2] || n_adv[3];
        n_adv[1] = !r_vld[1] || n_adv[2];
        n_prep_ctl.en1 = n_adv[1];
        n_prep_ctl.en2 = n_adv[2];
        n_prep_ctl.en3 = n_adv[3];
        n_ramp_ctl.en4 = n_adv[4];
        n_ramp_ctl.en5 = n_adv[5];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_adv[1]) r_vld[1] <= i_pix.valid;
            if (n_adv[2]) r_vld[2] <= r_vld[1];
            if (n_adv[3]) r_vld[3] <= r_vld[2];
            if (n_adv[4]) r_vld[4] <= r_vld[3];
            if (n_adv[5]) r_vld[5] <= r_vld[4];
        end
    end

    hsl_prep u_prep (
        .i_clk   (i_clk),
        .i_ctl   (n_prep_ctl),
        .i_hue   (i_pix.hue_deg),
        .i_sat   (i_pix.saturation),
        .i_light (i_pix.lightness),
        .o_lo    (n_lo),
        .o_hi    (n_hi),
        .o_span  (n_span),
        .o_chan  (n_chan)
    );

    for (genvar g = 0; g < 3; g++) begin : g_ramp
        hsl_ramp u_ramp (
            .i_clk   (i_clk),
            .i_ctl   (n_ramp_ctl),
            .i_chan  (n_chan[g]),
            .i_lo    (n_lo),
            .i_hi    (n_hi),
            .i_span  (n_span),
            .o_level (n_level[g])
        );
    end

    assign i_pix.ready = n_adv[1];
    assign o_rgb.valid = r_vld[5];
    assign o_rgb.red   = n_level[0];
    assign o_rgb.green = n_level[1];
    assign o_rgb.blue  = n_level[2];

endmodule

// ----- src/hsl_chk.sv -----
// hsl_chk: port-level checks on hsl_to_rgb_core, bound to the top level
// depends on hsl_pkg and hsl_to_rgb_core
module hsl_chk (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [hsl_pkg::LVL_W-1:0]   i_in_sat,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [hsl_pkg::LVL_W-1:0]   i_red,
    input  logic [hsl_pkg::LVL_W-1:0]   i_green,
    input  logic [hsl_pkg::LVL_W-1:0]   i_blue
);
    import hsl_pkg::*;

    logic n_in_acc;
    logic n_clear_run;

    assign n_in_acc = i_in_valid && i_in_ready;
    // output taking words and not in reset
    assign n_clear_run = i_out_ready && i_rst_n;

    // a stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_red) && $stable(i_green) && $stable(i_blue))
        else $error("output word changed while stalled");

    // levels never pass one
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_red <= ONE) && (i_green <= ONE) && (i_blue <= ONE))
        else $error("output level above one");

    // a word accepted into a free-running pipe comes out at o_rgb
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(n_in_acc, 5) && $past(i_rst_n, 5) && $past(n_clear_run, 1) &&
        $past(n_clear_run, 2) && $past(n_clear_run, 3) && $past(n_clear_run, 4)
        |-> i_out_valid)
        else $error("accepted word did not arrive after five cycles");

    // zero saturation gives grey
    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(n_in_acc && (i_in_sat == '0), 5) && $past(i_rst_n, 5) &&
        $past(n_clear_run, 1) && $past(n_clear_run, 2) &&
        $past(n_clear_run, 3) && $past(n_clear_run, 4)
        |-> i_out_valid && (i_red == i_green) && (i_green == i_blue))
        else $error("grey input gave unequal channels");

endmodule

bind hsl_to_rgb_core hsl_chk u_hsl_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_in_sat    (i_pix.saturation),
    .i_out_valid (o_rgb.valid),
    .i_out_ready (o_rgb.ready),
    .i_red       (o_rgb.red),
    .i_green     (o_rgb.green),
    .i_blue      (o_rgb.blue)
);

// ----- tb/hsl_to_rgb_checker.sv -----
// hsl_to_rgb_checker: watches both channels of hsl_to_rgb_core, predicts each rgb word
// and compares it with what comes out; depends on hsl_pkg, hsl_in_if, hsl_out_if
module hsl_to_rgb_checker (
    input  logic    i_clk,
    input  logic    i_rst_n,
    hsl_in_if       i_pix,
    hsl_out_if      i_rgb,
    output int      o_fail_count,
    output int      o_pending
);
    import hsl_pkg::*;

    localparam int UNITY    = 1 << FRAC_BITS;
    localparam int MIDPOINT = 1 << (FRAC_BITS - 1);
    localparam int FULL_TURN = 360;

    typedef struct packed {
        logic [LVL_W-1:0] red;
        logic [LVL_W-1:0] green;
        logic [LVL_W-1:0] blue;
    } t_rgb;

    t_rgb rgb_expected_q[$];
    t_rgb want;
    int   fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic int clamp_unity(int x);
        return (x > UNITY) ? UNITY : x;
    endfunction

    // level of one channel at angle d between the lower and upper levels
    function automatic int ramp_level(int lo, int hi, int d);
        int span;
        span = hi - lo;
        if (d < 60)
            return lo + (span * d) / 60;
        else if (d < 180)
            return hi;
        else if (d < 240)
            return lo + (span * (240 - d)) / 60;
        return lo;
    endfunction

    function automatic t_rgb convert_hsl(logic [HUE_W-1:0] hue, logic [LVL_W-1:0] sat,
                                         logic [LVL_W-1:0] lum);
        t_rgb c;
        int   h, s, l, ls, v1, v2, dr, db;
        h = int'(hue);
        s = clamp_unity(int'(sat));
        l = clamp_unity(int'(lum));
        if (h >= FULL_TURN)
            h -= FULL_TURN;
        if (s == 0) begin
            c.red   = LVL_W'(l);
            c.green = LVL_W'(l);
            c.blue  = LVL_W'(l);
            return c;
        end
        ls = (l * s) >>> FRAC_BITS;
        if (l < MIDPOINT)
            v2 = l + ls;
        else
            v2 = l + s - ls;
        v2 = clamp_unity(v2);
        if (v2 < l)
            v2 = l;
        v1 = 2 * l - v2;
        if (v1 < 0 || v1 > v2)
            v1 = v2;
        dr = h + 120;
        if (dr >= FULL_TURN)
            dr -= FULL_TURN;
        db = (h >= 120) ? h - 120 : h + 240;
        c.red   = LVL_W'(ramp_level(v1, v2, dr));
        c.green = LVL_W'(ramp_level(v1, v2, h));
        c.blue  = LVL_W'(ramp_level(v1, v2, db));
        return c;
    endfunction

    task automatic check_level(string name, logic [LVL_W-1:0] exp_val,
                               logic [LVL_W-1:0] got_val);
        if (exp_val !== got_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            fail_count++;
        end
    endtask

    // output side first: a word accepted at this edge cannot be the one leaving
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rgb_expected_q.delete();
        end else begin
            if (i_rgb.valid && i_rgb.ready) begin
                if (rgb_expected_q.size() == 0) begin
                    $error("rgb word with none expected: %0d %0d %0d",
                           i_rgb.red, i_rgb.green, i_rgb.blue);
                    fail_count++;
                end else begin
                    want = rgb_expected_q.pop_front();
                    check_level("red", want.red, i_rgb.red);
                    check_level("green", want.green, i_rgb.green);
                    check_level("blue", want.blue, i_rgb.blue);
                end
            end
            if (i_pix.valid && i_pix.ready)
                rgb_expected_q.insert(rgb_expected_q.size(),
                                      convert_hsl(i_pix.hue_deg, i_pix.saturation,
                                                  i_pix.lightness));
        end
        o_pending <= rgb_expected_q.size();
    end

endmodule

// ----- tb/hsl_to_rgb_core_tb.sv -----
// hsl_to_rgb_core_tb: drives hsl words into hsl_to_rgb_core with random idling on both
// sides; depends on hsl_pkg, the two channel interfaces and hsl_to_rgb_checker
module hsl_to_rgb_core_tb;
    import hsl_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int PHASE_WORDS = 234;
    localparam int N_DIRECTED  = 22;
    localparam int PIPE_DRAIN  = 10;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   src_idle_pct = 0;
    int   dst_idle_pct = 0;
    int   mismatches;
    int   in_flight;
    int   quiet_cycles = 0;

    // hue, saturation, lightness
    int directed_hsl[N_DIRECTED][3] = '{
        '{0, 0, 0},     '{359, 0, 256},   '{200, 0, 511},   '{0, 256, 128},
        '{59, 256, 128}, '{60, 256, 128}, '{119, 256, 128}, '{120, 256, 128},
        '{179, 200, 100}, '{180, 200, 100}, '{239, 200, 100}, '{240, 200, 100},
        '{359, 200, 100}, '{360, 100, 200}, '{511, 300, 50},  '{240, 511, 127},
        '{100, 256, 256}, '{300, 1, 1},     '{30, 128, 127},  '{30, 128, 128},
        '{330, 255, 255}, '{1, 257, 200}
    };

    hsl_in_if  pix ();
    hsl_out_if rgb ();

    hsl_to_rgb_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .o_rgb   (rgb)
    );

    hsl_to_rgb_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (pix),
        .i_rgb        (rgb),
        .o_fail_count (mismatches),
        .o_pending    (in_flight)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        rgb.ready <= ($urandom_range(0, 99) >= dst_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((pix.valid && pix.ready) || (rgb.valid && rgb.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_pixel(int hue, int sat, int lum);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            pix.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix.valid      <= 1'b1;
        pix.hue_deg    <= HUE_W'(hue);
        pix.saturation <= LVL_W'(sat);
        pix.lightness  <= LVL_W'(lum);
        @(posedge i_clk);
        while (!(pix.valid && pix.ready))
            @(posedge i_clk);
    endtask

    // hold the input off until every expected rgb word is out
    task automatic drain_pipe();
        pix.valid <= 1'b0;
        @(posedge i_clk);
        while (in_flight != 0)
            @(posedge i_clk);
    endtask

    // mostly legal levels, with some levels past 1.0; the caller adds hue past 359
    function automatic int random_level(int zero_pct);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < zero_pct)
            return 0;
        else if (pick < 85)
            return $urandom_range(0, 256);
        return $urandom_range(257, 511);
    endfunction

    initial begin
        pix.valid      = 1'b0;
        pix.hue_deg    = '0;
        pix.saturation = '0;
        pix.lightness  = '0;
        rgb.ready      = 1'b0;
        i_rst_n        = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_hsl[i])
            send_pixel(directed_hsl[i][0], directed_hsl[i][1], directed_hsl[i][2]);
        drain_pipe();

        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 47 : 0;
            dst_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 9 : 0;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                send_pixel(($urandom_range(0, 9) == 0) ? $urandom_range(360, 511)
                                                       : $urandom_range(0, 359),
                           random_level(10), random_level(5));
                if (phase == 0 && n == PHASE_WORDS / 2)
                    drain_pipe();
            end
            drain_pipe();
        end

        repeat (PIPE_DRAIN) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
